FILE: rtl/request_replay_cache_macros.svh
// Assertion macros shared by the request replay cache RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef REQUEST_REPLAY_CACHE_MACROS_SVH
`define REQUEST_REPLAY_CACHE_MACROS_SVH

`ifndef SYNTHESIS

`define RRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define RRC_NEVER(lbl, cond, msg) \
	`RRC_ASSERT(lbl, !(cond), msg)

`else

`define RRC_ASSERT(lbl, prop, msg)

`define RRC_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/rrc_pkg.sv
package rrc_pkg;

	localparam int ID_W    = 32;
	localparam int CMD_W   = 16;
	localparam int FLAGS_W = 16;
	localparam int KEY_W   = ID_W + CMD_W + FLAGS_W;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 3;

	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_RECORD = 1'b1
	} cmd_t;

	// The request id sits in the low bits, as on the input stream.
	typedef struct packed {
		logic [FLAGS_W-1:0] flags;
		logic [CMD_W-1:0]   command;
		logic [ID_W-1:0]    id;
	} key_t;

	typedef logic [STAMP_W-1:0] stamp_t;

endpackage

FILE: rtl/rrc_match.sv
module rrc_match #(
	parameter int SLOTS = 8,
	parameter int IDXW  = 3
) (
	input  rrc_pkg::key_t     key,
	input  rrc_pkg::key_t     entry_key [SLOTS],
	input  logic [SLOTS-1:0]  entry_valid,
	output logic              hit,
	output logic [IDXW-1:0]   hit_idx,
	output logic              free,
	output logic [IDXW-1:0]   free_idx
);
	import rrc_pkg::*;

	logic [SLOTS-1:0] match;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = entry_valid[i] && (entry_key[i] == key);
		end
	end

	// Priority encoders: the lowest index wins.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = IDXW'(i);
			end
			if (!entry_valid[i]) begin
				free     = 1'b1;
				free_idx = IDXW'(i);
			end
		end
	end

endmodule

FILE: rtl/rrc_victim.sv
module rrc_victim #(
	parameter int SLOTS = 8,
	parameter int IDXW  = 3
) (
	input  rrc_pkg::stamp_t  stamp [SLOTS],
	output logic [IDXW-1:0]  victim_idx
);
	import rrc_pkg::*;

	localparam int LEAVES = 1 << IDXW;

	// Heap-numbered tournament tree: node k has children 2k and 2k+1.
	stamp_t          node_stamp [1:2*LEAVES-1];
	logic [IDXW-1:0] node_idx   [1:2*LEAVES-1];
	logic            node_use   [1:2*LEAVES-1];

	genvar g;
	generate
		for (g = 0; g < LEAVES; g++) begin : g_leaf
			if (g < SLOTS) begin : g_real
				assign node_stamp[LEAVES+g] = stamp[g];
				assign node_use[LEAVES+g]   = 1'b1;
			end else begin : g_pad
				assign node_stamp[LEAVES+g] = '0;
				assign node_use[LEAVES+g]   = 1'b0;
			end
			assign node_idx[LEAVES+g] = IDXW'(g);
		end

		for (g = 1; g < LEAVES; g++) begin : g_node
			logic take_right;

			// The left child holds lower indices, so it keeps ties.
			assign take_right = node_use[2*g+1] &&
				(!node_use[2*g] || (node_stamp[2*g+1] < node_stamp[2*g]));
			assign node_stamp[g] = take_right ? node_stamp[2*g+1] : node_stamp[2*g];
			assign node_idx[g]   = take_right ? node_idx[2*g+1] : node_idx[2*g];
			assign node_use[g]   = node_use[2*g] || node_use[2*g+1];
		end
	endgenerate

	assign victim_idx = node_idx[1];

endmodule

FILE: rtl/request_replay_cache.sv
// Request replay cache: a table of SLOTS answered requests keyed by request id,
// command and flags, with a recency stamp and a stored response length per entry.
// Input stream s_*: s_tuser carries the command (0 lookup, 1 record); s_tdata
// carries request id, command code, flags and response length.
// Output stream m_*: one transfer per input transfer, in order. m_tuser is the hit
// flag; m_tdata carries the slot and the stored length.
// A lookup returns the first valid matching slot and refreshes its stamp; a miss
// returns hit, slot and length all zero. A record fills the first free slot, or
// else the least recently used one, and returns that slot and the new length.
// An input transfer is captured in the input register, where the search and table
// update run, and the result then enters the output register. Throughput is one
// transfer per cycle while the output is taken, set by the single pass of compare
// and stamp tree between those two registers.
// When m_tready is low the result holds in the output register and one more item
// waits in the input register; s_tready then drops until the result is taken.
// Reset clears all valid marks and the stamp counter at once; the block is ready
// for a transfer as soon as reset is released.
`include "request_replay_cache_macros.svh"

module request_replay_cache #(
	parameter int  SLOTS       = 8,
	parameter int  LENGTH_BITS = 11,
	localparam int S_TDATA_W   = ((rrc_pkg::KEY_W + LENGTH_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W   = ((rrc_pkg::SLOT_W + LENGTH_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // req_id, req_command, req_flags, resp_length
	input  logic                 s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // slot, stored_length
	output logic                 m_tuser   // hit
);
	import rrc_pkg::*;

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	key_t                   key_s1;
	logic [LENGTH_BITS-1:0] len_s1;

	logic [SLOTS-1:0]       entry_valid_q;
	key_t                   entry_key_q [SLOTS];
	stamp_t                 entry_stamp_q [SLOTS];
	logic [LENGTH_BITS-1:0] entry_len_q [SLOTS];
	stamp_t                 stamp_cnt_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [LENGTH_BITS-1:0] out_len_q;

	logic                   fire;
	logic                   match_hit;
	logic [IDXW-1:0]        hit_idx;
	logic                   any_free;
	logic [IDXW-1:0]        free_idx;
	logic [IDXW-1:0]        victim_idx;
	logic [IDXW-1:0]        pick_idx;
	logic [IDXW-1:0]        res_idx;
	logic [IDXW+SLOT_W-1:0] res_idx_ext;
	stamp_t                 stamp_next;
	logic                   is_record;
	logic                   do_refresh;

	rrc_match #(
		.SLOTS(SLOTS),
		.IDXW (IDXW)
	) u_match (
		.key        (key_s1),
		.entry_key  (entry_key_q),
		.entry_valid(entry_valid_q),
		.hit        (match_hit),
		.hit_idx    (hit_idx),
		.free       (any_free),
		.free_idx   (free_idx)
	);

	rrc_victim #(
		.SLOTS(SLOTS),
		.IDXW (IDXW)
	) u_victim (
		.stamp     (entry_stamp_q),
		.victim_idx(victim_idx)
	);

	assign fire       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || fire;
	assign is_record  = (cmd_s1 == CMD_RECORD);
	assign do_refresh = !is_record && match_hit;
	assign pick_idx   = any_free ? free_idx : victim_idx;
	assign res_idx    = is_record ? pick_idx : hit_idx;
	assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};
	assign stamp_next = (stamp_cnt_q == STAMP_MAX) ? stamp_cnt_q : stamp_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_t'(s_tuser);
			key_s1 <= key_t'(s_tdata[KEY_W-1:0]);
			len_s1 <= s_tdata[KEY_W +: LENGTH_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			stamp_cnt_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire && is_record) begin
				entry_valid_q[pick_idx] <= 1'b1;
			end
			if (fire && (is_record || do_refresh)) begin
				stamp_cnt_q <= stamp_next;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_record) begin
			entry_key_q[pick_idx]   <= key_s1;
			entry_stamp_q[pick_idx] <= stamp_next;
			entry_len_q[pick_idx]   <= len_s1;
		end else if (fire && do_refresh) begin
			entry_stamp_q[hit_idx] <= stamp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_record) begin
				out_hit_q  <= 1'b0;
				out_slot_q <= res_idx_ext[SLOT_W-1:0];
				out_len_q  <= len_s1;
			end else if (match_hit) begin
				out_hit_q  <= 1'b1;
				out_slot_q <= res_idx_ext[SLOT_W-1:0];
				out_len_q  <= entry_len_q[hit_idx];
			end else begin
				out_hit_q  <= 1'b0;
				out_slot_q <= '0;
				out_len_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[SLOT_W-1:0]           = out_slot_q;
		m_tdata[SLOT_W +: LENGTH_BITS] = out_len_q;
	end

	`RRC_ASSERT(a_stamp_monotonic, stamp_cnt_q >= $past(stamp_cnt_q), "stamp counter went backwards")
	`RRC_NEVER(a_hit_on_invalid, match_hit && !entry_valid_q[hit_idx], "hit reported on an invalid entry")
	`RRC_NEVER(a_evict_with_free, fire && is_record && any_free && entry_valid_q[pick_idx], "record overwrote a valid entry while a free slot existed")
	`RRC_ASSERT(a_record_sets_valid, fire && is_record |=> entry_valid_q[$past(pick_idx)], "recorded slot is not valid")

endmodule
